// ===== sv/lrc_pkg.sv =====
`default_nettype none
package lrc_pkg;

  // Default store depth and fixed field widths
  localparam int ENTRIES_DEF = 64;
  localparam int WORDS       = 6;
  localparam int WORD_W      = 32;
  localparam int KEY_W       = 64;

  // Request codes; the fourth code is ignored
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Request word
  typedef struct packed {
    logic [1:0]        command;
    logic [WORD_W-1:0] effect_id;
    logic [WORD_W-1:0] frame_number;
    logic [WORD_W-1:0] pos_x_in;
    logic [WORD_W-1:0] pos_y_in;
    logic [WORD_W-1:0] pos_z_in;
    logic [WORD_W-1:0] rot_x_in;
    logic [WORD_W-1:0] rot_y_in;
    logic [WORD_W-1:0] rot_z_in;
  } lrc_in_t;

  // Result word
  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] pos_x_out;
    logic [WORD_W-1:0] pos_y_out;
    logic [WORD_W-1:0] pos_z_out;
    logic [WORD_W-1:0] rot_x_out;
    logic [WORD_W-1:0] rot_y_out;
    logic [WORD_W-1:0] rot_z_out;
    logic [WORD_W-1:0] hit_total;
    logic [WORD_W-1:0] miss_total;
  } lrc_out_t;

  // One cached entry as it moves along the cell chain
  typedef struct packed {
    logic [KEY_W-1:0]             key;
    logic [WORDS-1:0][WORD_W-1:0] words;
  } lrc_entry_t;

endpackage
`default_nettype wire

// ===== sv/lrc_cell.sv =====
`default_nettype none
module lrc_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cmp_en,
  input  wire logic [lrc_pkg::KEY_W-1:0] cmp_key,
  input  wire logic                      cell_vld,
  input  wire logic                      load,
  input  wire lrc_pkg::lrc_entry_t       up_entry,
  output lrc_pkg::lrc_entry_t            entry,
  output logic                           match
);
  import lrc_pkg::*;

  lrc_entry_t entry_r;
  logic       match_r;

  // Take the upstream neighbor's entry when the chain shifts through here
  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= up_entry;
    end
  end

  // Compare the held key against the request key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= cmp_en && cell_vld && (entry_r.key == cmp_key);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

  a_match_src: assert property (@(posedge clk) disable iff (!rst_n)
    match_r |-> $past(cmp_en && cell_vld))
    else $error("cell match without a valid compare");

endmodule
`default_nettype wire

// ===== sv/lru_result_cache_core.sv =====
`default_nettype none
// Sequence: an accepted request is registered, every cell compares its key in the
//   compare state, and the result register and strobe are loaded in the update state.
// Flow: a key compare in every cell, then selection and move-to-front shift along
//   the chain; a new request can be accepted in the update state, but not in compare.
// Reset: synchronous; clears the fill count, the hit and miss totals and the
//   control state. Cached entries are not cleared. Results cannot be stalled.
module lru_result_cache_core #(
  parameter int ENTRIES = lrc_pkg::ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire lrc_pkg::lrc_in_t in_word,
  output logic                  out_valid,
  output lrc_pkg::lrc_out_t     out_word
);
  import lrc_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t       state_r;
  lrc_in_t      req_r;
  lrc_out_t     out_r, out_nxt;
  logic         out_valid_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [WORD_W-1:0] hit_cnt_r, hit_cnt_nxt, miss_cnt_r, miss_cnt_nxt;

  lrc_entry_t   cell_entry [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] load_vec;
  lrc_entry_t   front;
  logic [KEY_W-1:0] req_key;
  logic         hit;
  logic [IW-1:0] pos;
  logic [WORDS-1:0][WORD_W-1:0] hit_words;
  logic         upd_en;
  logic [IW-1:0] lim;

  assign req_key = {req_r.effect_id, req_r.frame_number};
  assign busy    = (state_r == ST_CMP);

  // Row of cells, position 0 holds the most recent entry
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrc_entry_t up;
    if (i == 0) begin : g_head
      assign up = front;
    end else begin : g_link
      assign up = cell_entry[i-1];
    end
    assign load_vec[i] = (state_r == ST_UPD) && upd_en && (IW'(i) <= lim);
    lrc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmp_en   (state_r == ST_CMP),
      .cmp_key  (req_key),
      .cell_vld (CW'(i) < count_r),
      .load     (load_vec[i]),
      .up_entry (up),
      .entry    (cell_entry[i]),
      .match    (match_vec[i])
    );
  end

  // Merge the single matching cell into hit flag, position and payload
  always_comb begin
    hit       = |match_vec;
    pos       = '0;
    hit_words = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        pos       = pos | IW'(i);
        hit_words = hit_words | cell_entry[i].words;
      end
    end
  end

  // Decide the shift span, the new front entry and the next totals
  always_comb begin
    upd_en       = 1'b0;
    lim          = '0;
    count_nxt    = count_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    front.key    = req_key;
    front.words  = {req_r.rot_z_in, req_r.rot_y_in, req_r.rot_x_in,
                    req_r.pos_z_in, req_r.pos_y_in, req_r.pos_x_in};
    out_nxt      = '0;
    unique case (req_r.command)
      CMD_LOOKUP: begin
        if (hit) begin
          upd_en      = 1'b1;
          lim         = pos;
          front.words = hit_words;
          hit_cnt_nxt = hit_cnt_r + 1'b1;
          out_nxt.hit       = 1'b1;
          out_nxt.pos_x_out = hit_words[0];
          out_nxt.pos_y_out = hit_words[1];
          out_nxt.pos_z_out = hit_words[2];
          out_nxt.rot_x_out = hit_words[3];
          out_nxt.rot_y_out = hit_words[4];
          out_nxt.rot_z_out = hit_words[5];
        end else begin
          miss_cnt_nxt = miss_cnt_r + 1'b1;
        end
      end
      CMD_INSERT: begin
        upd_en = 1'b1;
        if (hit) begin
          lim = pos;
        end else if (count_r == CW'(ENTRIES)) begin
          // full: the least recent entry drops off the tail
          lim = IW'(ENTRIES - 1);
        end else begin
          lim       = count_r[IW-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    out_nxt.hit_total  = hit_cnt_nxt;
    out_nxt.miss_total = miss_cnt_nxt;
  end

  // Sequence compare and update, hold totals and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r   <= in_word;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          out_valid_r <= 1'b1;
          out_r       <= out_nxt;
          count_r     <= count_nxt;
          hit_cnt_r   <= hit_cnt_nxt;
          miss_cnt_r  <= miss_cnt_nxt;
          if (start) begin
            req_r   <= in_word;
            state_r <= ST_CMP;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_cmp_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("compare phase longer than one cycle");

  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_UPD))
    else $error("result strobe without an update phase");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("fill count beyond store depth");

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("key matched in more than one cell");

endmodule
`default_nettype wire
